// ----- design/ac_pkg.sv -----
package ac_pkg;

  localparam int NUM_STATES = 4096;
  localparam int ALPHABET = 256;
  localparam int NUM_OUTPUTS = 4096;
  localparam int MAX_MATCHES_PER_BYTE = 64;

  localparam int STATE_W = $clog2(NUM_STATES);
  localparam int SYM_W = $clog2(ALPHABET);
  localparam int OUT_W = $clog2(NUM_OUTPUTS);
  localparam int TT_W = STATE_W + SYM_W;
  localparam int LINK_W = 13;
  localparam int PAT_W = 16;
  localparam int POS_W = 40;
  localparam int ADDR_W = 20;
  localparam int CNT_W = $clog2(MAX_MATCHES_PER_BYTE) + 1;
  localparam int BUF_W = $clog2(MAX_MATCHES_PER_BYTE);
  localparam int IN_DATA_W = 104;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [2:0] {
    REQ_SCAN     = 3'd0,
    REQ_GOTO     = 3'd1,
    REQ_HEAD     = 3'd2,
    REQ_SUFFIX   = 3'd3,
    REQ_OUTENTRY = 3'd4
  } req_t;

  typedef struct packed {
    logic wr_table;
    logic scan;
    logic step_state;
    logic rd_out_head;
    logic buf_wr;
    logic rd_out_link;
    logic hop;
    logic set_trunc;
    logic emit_start;
    logic load_out;
  } ac_cmd_t;

  typedef struct packed {
    logic is_scan;
    logic owned;
    logic head_none;
    logic link_none;
    logic suf_none;
    logic n_full;
    logic n_last_slot;
    logic hops_last;
    logic n_zero;
    logic emit_last;
    logic out_free;
  } ac_sts_t;

endpackage

// ----- design/ac_ctrl.sv -----
module ac_ctrl
  import ac_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  input  ac_sts_t sts,
  output logic    idle,
  output ac_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_TRD  = 5'b00010,
    S_HRD  = 5'b00100,
    S_ORD  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign idle = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    logic finish;
    logic step;
    finish = 1'b0;
    step = 1'b0;
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (sts.is_scan) begin
            cmd.scan = 1'b1;
            state_nxt = S_TRD;
          end else begin
            cmd.wr_table = 1'b1;
          end
        end
      end
      S_TRD: begin
        cmd.step_state = 1'b1;
        state_nxt = sts.owned ? S_HRD : S_IDLE;
      end
      S_HRD: begin
        if (sts.head_none) begin
          step = 1'b1;
        end else if (sts.n_full) begin
          cmd.set_trunc = 1'b1;
          finish = 1'b1;
        end else begin
          cmd.rd_out_head = 1'b1;
          state_nxt = S_ORD;
        end
      end
      S_ORD: begin
        cmd.buf_wr = 1'b1;
        if (sts.link_none) begin
          step = 1'b1;
        end else if (sts.n_last_slot) begin
          cmd.set_trunc = 1'b1;
          finish = 1'b1;
        end else begin
          cmd.rd_out_link = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.emit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // advance along the dictionary suffix chain, or end the walk
    if (step) begin
      if (sts.hops_last || sts.suf_none) begin
        finish = 1'b1;
      end else begin
        cmd.hop = 1'b1;
        state_nxt = S_HRD;
      end
    end
    if (finish) begin
      if (sts.n_zero && !(cmd.buf_wr)) begin
        state_nxt = S_IDLE;
      end else begin
        cmd.emit_start = 1'b1;
        state_nxt = S_EMIT;
      end
    end
  end

endmodule

// ----- design/ac_dp.sv -----
module ac_dp
  import ac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [2:0]            req_type,
  input  logic [SYM_W-1:0]      text_byte,
  input  logic                  block_start,
  input  logic                  owned,
  input  logic [POS_W-1:0]      text_pos,
  input  logic [ADDR_W-1:0]     table_addr,
  input  logic [LINK_W-1:0]     table_value,
  input  logic [PAT_W-1:0]      entry_pattern,
  input  ac_cmd_t               cmd,
  output ac_sts_t               sts,
  input  logic                  out_tready,
  output logic                  out_valid,
  output logic [POS_W-1:0]      out_pos,
  output logic [PAT_W-1:0]      out_pat,
  output logic                  out_last,
  output logic                  out_trunc
);

  logic [STATE_W-1:0]  trans_mem [NUM_STATES*ALPHABET];
  logic [LINK_W-1:0]   head_mem [NUM_STATES];
  logic [LINK_W-1:0]   suf_mem [NUM_STATES];
  logic [LINK_W-1:0]   link_mem [NUM_OUTPUTS];
  logic [PAT_W-1:0]    pat_mem [NUM_OUTPUTS];
  logic [PAT_W-1:0]    buf_mem [MAX_MATCHES_PER_BYTE];

  logic [STATE_W-1:0]  trans_q, cur_r;
  logic [LINK_W-1:0]   head_q, suf_q, link_q;
  logic [PAT_W-1:0]    pat_q, buf_q;
  logic [POS_W-1:0]    pos_r;
  logic                owned_r, trunc_r;
  logic [CNT_W-1:0]    n_r, k_r;
  logic [STATE_W-1:0]  hops_r;
  logic                out_valid_r, out_last_r, out_trunc_r;
  logic [POS_W-1:0]    out_pos_r;
  logic [PAT_W-1:0]    out_pat_r;

  logic                rd_hs;
  logic [STATE_W-1:0]  hs_addr;
  logic                rd_o;
  logic [OUT_W-1:0]    o_addr;
  logic [CNT_W-1:0]    k_next;
  logic [STATE_W-1:0]  scan_state;

  assign scan_state = block_start ? '0 : cur_r;
  assign rd_hs = cmd.step_state | cmd.hop;
  assign hs_addr = cmd.step_state ? trans_q : suf_q[STATE_W-1:0];
  assign rd_o = cmd.rd_out_head | cmd.rd_out_link;
  assign o_addr = cmd.rd_out_head ? head_q[OUT_W-1:0] : link_q[OUT_W-1:0];
  assign k_next = cmd.emit_start ? '0 : k_r + CNT_W'(1);

  // table stores: write on table transactions, registered reads
  always_ff @(posedge clk) begin
    if (cmd.wr_table && req_type == REQ_GOTO) begin
      trans_mem[table_addr[TT_W-1:0]] <= table_value[LINK_W-1] ? '0 :
                                         table_value[STATE_W-1:0];
    end
    if (cmd.scan) begin
      trans_q <= trans_mem[{scan_state, text_byte}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_table && req_type == REQ_HEAD && table_addr[ADDR_W-1:STATE_W] == '0) begin
      head_mem[table_addr[STATE_W-1:0]] <= table_value;
    end
    if (rd_hs) begin
      head_q <= head_mem[hs_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_table && req_type == REQ_SUFFIX && table_addr[ADDR_W-1:STATE_W] == '0) begin
      suf_mem[table_addr[STATE_W-1:0]] <= table_value;
    end
    if (rd_hs) begin
      suf_q <= suf_mem[hs_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_table && req_type == REQ_OUTENTRY &&
        table_addr[ADDR_W-1:OUT_W] == '0) begin
      link_mem[table_addr[OUT_W-1:0]] <= table_value;
      pat_mem[table_addr[OUT_W-1:0]] <= entry_pattern;
    end
    if (rd_o) begin
      link_q <= link_mem[o_addr];
      pat_q <= pat_mem[o_addr];
    end
  end

  // per-byte match buffer
  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      buf_mem[n_r[BUF_W-1:0]] <= pat_q;
    end
    // forward the first entry when it is written in the cycle the emit starts
    if (cmd.emit_start && cmd.buf_wr && n_r == '0) begin
      buf_q <= pat_q;
    end else if (cmd.emit_start || cmd.load_out) begin
      buf_q <= buf_mem[k_next[BUF_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      n_r <= '0;
      k_r <= '0;
      hops_r <= '0;
      trunc_r <= 1'b0;
      owned_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan) begin
        owned_r <= owned;
      end
      if (cmd.step_state) begin
        cur_r <= trans_q;
        n_r <= '0;
        hops_r <= '0;
        trunc_r <= 1'b0;
      end
      if (cmd.buf_wr) begin
        n_r <= n_r + CNT_W'(1);
      end
      if (cmd.hop) begin
        hops_r <= hops_r + STATE_W'(1);
      end
      if (cmd.set_trunc) begin
        trunc_r <= 1'b1;
      end
      if (cmd.emit_start || cmd.load_out) begin
        k_r <= k_next;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      pos_r <= text_pos;
    end
    if (cmd.load_out) begin
      out_pos_r <= pos_r;
      out_pat_r <= buf_q;
      out_last_r <= sts.emit_last;
      out_trunc_r <= trunc_r;
    end
  end

  always_comb begin
    sts.is_scan = (req_type == REQ_SCAN);
    sts.owned = owned_r;
    sts.head_none = head_q[LINK_W-1];
    sts.link_none = link_q[LINK_W-1];
    sts.suf_none = suf_q[LINK_W-1];
    sts.n_full = (n_r == CNT_W'(MAX_MATCHES_PER_BYTE));
    sts.n_last_slot = (n_r == CNT_W'(MAX_MATCHES_PER_BYTE - 1));
    sts.hops_last = (hops_r == STATE_W'(NUM_STATES - 1));
    sts.n_zero = (n_r == '0);
    sts.emit_last = (k_r + CNT_W'(1) == n_r);
    sts.out_free = !out_valid_r || out_tready;
  end

  assign out_valid = out_valid_r;
  assign out_pos = out_pos_r;
  assign out_pat = out_pat_r;
  assign out_last = out_last_r;
  assign out_trunc = out_trunc_r;

endmodule

// ----- design/aho_corasick_scanner.sv -----
// Flow: a scan transaction reads the goto table, then updates the state; an owned
//   byte then walks the suffix chain, reading the output entries of each state,
//   then results leave at 1 per cycle unless out_tready holds them (buffered so
//   last/truncated are known). Table writes are taken 1 per cycle; a new scan is
//   taken only once the walk and emit are done. Reset (sync, active low) returns to
//   root state; tables are not cleared.
module aho_corasick_scanner
  import ac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // text_byte[7:0], block_start[8], owned[9], text_pos[49:10], table_addr[69:50],
  // table_value[82:70], entry_pattern[98:83], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type[2:0]
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // match_pos[39:0], pattern_num[55:40]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // truncated[0]
  output logic                  out_tuser,
  // last_match
  output logic                  out_tlast
);

  ac_cmd_t cmd;
  ac_sts_t sts;
  logic    idle;
  logic    in_fire;
  logic [POS_W-1:0] out_pos;
  logic [PAT_W-1:0] out_pat;

  // take transactions only between walks; the output register frees the input side
  assign in_tready = idle;
  assign in_fire = in_tvalid && in_tready;

  ac_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  ac_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_type      (in_tuser),
    .text_byte     (in_tdata[7:0]),
    .block_start   (in_tdata[8]),
    .owned         (in_tdata[9]),
    .text_pos      (in_tdata[49:10]),
    .table_addr    (in_tdata[69:50]),
    .table_value   (in_tdata[82:70]),
    .entry_pattern (in_tdata[98:83]),
    .cmd           (cmd),
    .sts           (sts),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .out_pos       (out_pos),
    .out_pat       (out_pat),
    .out_last      (out_tlast),
    .out_trunc     (out_tuser)
  );

  assign out_tdata = {out_pat, out_pos};

endmodule
